// File: src/dsbh_pkg.sv
// Package for the drive, saturate, bit-crush and hold block.
// Holds shared widths, register indexes, controller/datapath command types
// and the tanh and 2^x lookup tables. No dependencies.
package dsbh_pkg;

  // Default number of channels with hold state.
  localparam int CHANNELS_DEF = 2;

  // Shared divider geometry: numerator, denominator and quotient widths.
  localparam int DIV_NW = 42;
  localparam int DIV_DW = 26;
  localparam int DIV_QW = 18;

  // Fixed-point constants.
  localparam logic [16:0] AMOUNT_ONE = 17'd65536;
  localparam logic [16:0] CRUSH_KNEE = 17'd22938;
  // ceil(2^48 / 42598): (d * CRUSH_RECIP) >> 32 equals floor(d * 2^16 / 42598)
  // exactly for any 16-bit d.
  localparam logic [32:0] CRUSH_RECIP = 33'd6607704041;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GRIT_MODE   = 1'b0;
  localparam cfg_idx_t CFG_RATE_FACTOR = 1'b1;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DRIVE,
    OP_SHAPE,
    OP_TANH,
    OP_TSCALE,
    OP_GRES,
    OP_CRES,
    OP_EXPO,
    OP_NMUL,
    OP_QRES,
    OP_HOLD,
    OP_ORES
  } dp_op_t;

  // Operand set handed to the shared divider.
  typedef enum logic [1:0] {
    DIV_GRIT,
    DIV_QUANT,
    DIV_OUT
  } div_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     div_start;
    div_sel_t div_sel;
  } dsbh_cmd_t;

  typedef struct packed {
    logic grit;
    logic neg;
    logic crush_on;
    logic div_busy;
  } dsbh_stat_t;

  // tanh(k/8) in Q15 for k = 0..48.
  function automatic logic [15:0] tanh_lut(input logic [5:0] idx);
    logic [15:0] v;
    unique case (idx)
      6'd0:  v = 16'd0;
      6'd1:  v = 16'd4075;
      6'd2:  v = 16'd8025;
      6'd3:  v = 16'd11743;
      6'd4:  v = 16'd15143;
      6'd5:  v = 16'd18173;
      6'd6:  v = 16'd20813;
      6'd7:  v = 16'd23066;
      6'd8:  v = 16'd24956;
      6'd9:  v = 16'd26519;
      6'd10: v = 16'd27797;
      6'd11: v = 16'd28830;
      6'd12: v = 16'd29660;
      6'd13: v = 16'd30322;
      6'd14: v = 16'd30847;
      6'd15: v = 16'd31262;
      6'd16: v = 16'd31589;
      6'd17: v = 16'd31846;
      6'd18: v = 16'd32048;
      6'd19: v = 16'd32206;
      6'd20: v = 16'd32329;
      6'd21: v = 16'd32426;
      6'd22: v = 16'd32501;
      6'd23: v = 16'd32560;
      6'd24: v = 16'd32606;
      6'd25: v = 16'd32642;
      6'd26: v = 16'd32670;
      6'd27: v = 16'd32691;
      6'd28: v = 16'd32708;
      6'd29: v = 16'd32721;
      6'd30: v = 16'd32732;
      6'd31: v = 16'd32740;
      6'd32: v = 16'd32746;
      6'd33: v = 16'd32751;
      6'd34: v = 16'd32755;
      6'd35: v = 16'd32758;
      6'd36: v = 16'd32760;
      6'd37: v = 16'd32762;
      6'd38: v = 16'd32763;
      6'd39: v = 16'd32764;
      6'd40: v = 16'd32765;
      6'd41: v = 16'd32766;
      6'd42: v = 16'd32766;
      6'd43: v = 16'd32767;
      6'd44: v = 16'd32767;
      6'd45: v = 16'd32767;
      6'd46: v = 16'd32767;
      6'd47: v = 16'd32767;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

  // 2^(k/16) in Q14 for k = 0..16.
  function automatic logic [15:0] exp2_lut(input logic [4:0] idx);
    logic [15:0] v;
    unique case (idx)
      5'd0:  v = 16'd16384;
      5'd1:  v = 16'd17109;
      5'd2:  v = 16'd17867;
      5'd3:  v = 16'd18658;
      5'd4:  v = 16'd19484;
      5'd5:  v = 16'd20347;
      5'd6:  v = 16'd21247;
      5'd7:  v = 16'd22188;
      5'd8:  v = 16'd23170;
      5'd9:  v = 16'd24196;
      5'd10: v = 16'd25268;
      5'd11: v = 16'd26386;
      5'd12: v = 16'd27554;
      5'd13: v = 16'd28774;
      5'd14: v = 16'd30048;
      5'd15: v = 16'd31379;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

endpackage

// File: src/dsbh_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// No dependencies.
interface dsbh_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  logic [16:0]        amount;
  logic               channel;

  modport source(output valid, sample_in, amount, channel, input ready);
  modport sink(input valid, sample_in, amount, channel, output ready);
endinterface

interface dsbh_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;

  modport source(output valid, sample_out, input ready);
  modport sink(input valid, sample_out, output ready);
endinterface

// File: src/dsbh_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on dsbh_pkg for its widths.
module dsbh_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dsbh_pkg::DIV_NW-1:0]  num,
  input  logic [dsbh_pkg::DIV_DW-1:0]  den,
  output logic                         busy,
  output logic [dsbh_pkg::DIV_QW-1:0]  quo
);
  import dsbh_pkg::*;

  localparam int CNT_W = $clog2(DIV_QW);

  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_QW-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic [DIV_DW:0]   trial;
  logic              ge;

  // One trial subtraction; the numerator shifts out as quotient bits shift in.
  always_comb begin
    trial   = {rem_r, acc_r[DIV_QW-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DIV_DW'(trial - {1'b0, den_r}) : DIV_DW'(trial);
    acc_nxt = {acc_r[DIV_QW-2:0], ge};
  end

  // Control: step counter and busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_QW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DIV_DW'(num[DIV_NW-1:DIV_QW]);
      acc_r <= num[DIV_QW-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = acc_r;
endmodule

// File: src/dsbh_ctrl.sv
// Controller state machine: sequences the datapath steps for one word and
// runs the output handshake. Depends on dsbh_pkg.
module dsbh_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dsbh_pkg::dsbh_stat_t stat,
  output dsbh_pkg::dsbh_cmd_t  cmd
);
  import dsbh_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'h0001,
    S_DRIVE  = 14'h0002,
    S_SHAPE  = 14'h0004,
    S_TANH   = 14'h0008,
    S_TSCALE = 14'h0010,
    S_GWAIT  = 14'h0020,
    S_CRUSH  = 14'h0040,
    S_EXPO   = 14'h0080,
    S_NMUL   = 14'h0100,
    S_QSTART = 14'h0200,
    S_QWAIT  = 14'h0400,
    S_HOLD   = 14'h0800,
    S_OSTART = 14'h1000,
    S_OWAIT  = 14'h2000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // Next state and datapath command.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '{op: OP_NONE, div_start: 1'b0, div_sel: DIV_GRIT};
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DRIVE;
        end
      end
      S_DRIVE: begin
        cmd.op    = OP_DRIVE;
        state_nxt = S_SHAPE;
      end
      S_SHAPE: begin
        cmd.op = OP_SHAPE;
        if (stat.grit && !stat.neg) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_GRIT;
          state_nxt     = S_GWAIT;
        end else begin
          state_nxt = S_TANH;
        end
      end
      S_TANH: begin
        cmd.op    = OP_TANH;
        state_nxt = S_TSCALE;
      end
      S_TSCALE: begin
        cmd.op    = OP_TSCALE;
        state_nxt = stat.crush_on ? S_CRUSH : S_HOLD;
      end
      S_GWAIT: begin
        if (!stat.div_busy) begin
          cmd.op    = OP_GRES;
          state_nxt = stat.crush_on ? S_CRUSH : S_HOLD;
        end
      end
      S_CRUSH: begin
        cmd.op    = OP_CRES;
        state_nxt = S_EXPO;
      end
      S_EXPO: begin
        cmd.op    = OP_EXPO;
        state_nxt = S_NMUL;
      end
      S_NMUL: begin
        cmd.op    = OP_NMUL;
        state_nxt = S_QSTART;
      end
      S_QSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_QUANT;
        state_nxt     = S_QWAIT;
      end
      S_QWAIT: begin
        if (!stat.div_busy) begin
          cmd.op    = OP_QRES;
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        cmd.op    = OP_HOLD;
        state_nxt = S_OSTART;
      end
      S_OSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_OUT;
        state_nxt     = S_OWAIT;
      end
      S_OWAIT: begin
        // The result register is written only once the previous word has left.
        if (!stat.div_busy && slot_free) begin
          cmd.op        = OP_ORES;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
endmodule

// File: src/dsbh_dp.sv
// Datapath: drive, tanh/grit shaping, crush quantizer, per-channel hold and
// output compensation, with the shared divider. Depends on dsbh_pkg, dsbh_div.
module dsbh_dp #(
  parameter int CHANNELS = dsbh_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  dsbh_pkg::cfg_idx_t                cfg_index,
  input  logic [dsbh_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [15:0]                in_sample,
  input  logic [16:0]                       in_amount,
  input  logic                              in_channel,
  input  dsbh_pkg::dsbh_cmd_t               cmd,
  output dsbh_pkg::dsbh_stat_t              stat,
  output logic signed [15:0]                out_sample
);
  import dsbh_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  logic       grit_mode_r;
  logic [3:0] rate_factor_r;

  // Per-item working registers.
  logic               neg_r;
  logic [16:0]        xm_r;
  logic [16:0]        r_r;
  logic [CH_W-1:0]    ch_r;
  logic               crush_on_r;
  logic [18:0]        dm_r;
  logic [17:0]        den_r;
  logic [19:0]        a_r;
  logic [15:0]        t_r;
  logic signed [17:0] s_r;
  logic [16:0]        c_r;
  logic [15:0]        m_r;
  logic [4:0]         ip_r;
  logic [25:0]        p_r;
  logic [17:0]        n_r;
  logic [15:0]        hm_r;
  logic               hneg_r;
  logic signed [15:0] out_sample_r;

  // Hold state per channel.
  logic signed [15:0] held_r [CHANNELS];
  logic [6:0]         rem_r  [CHANNELS];

  // Load.
  logic [16:0]     amt_c;
  logic [16:0]     xm_c;
  logic [CH_W-1:0] ch_c;
  // Drive and compensation denominator.
  logic [19:0]     drive_c;
  logic [36:0]     dprod_c;
  logic [18:0]     dm_c;
  logic [33:0]     rprod_c;
  logic [17:0]     den_c;
  // Shaping.
  logic [34:0]     gprod_c;
  logic [19:0]     ga_c;
  logic [7:0]      ti_c;
  logic [15:0]     t0_c, t1_c;
  logic [12:0]     tdiff_c;
  logic [24:0]     tmul_c;
  logic [15:0]     tint_c, tv_c;
  logic [30:0]     yprod_c;
  logic [14:0]     y_c;
  logic signed [17:0] tsx_c, ysx_c, ts_c;
  // Crush.
  logic [15:0]     cdiff_c;
  logic [48:0]     cprod_c;
  logic [16:0]     c_c;
  logic [20:0]     e_c;
  logic [15:0]     m0_c, m1_c;
  logic [10:0]     mdiff_c;
  logic [22:0]     mmul_c;
  logic [15:0]     m_c;
  logic [25:0]     p_c;
  logic [16:0]     smag_c;
  logic [42:0]     nprod_c;
  logic [17:0]     n_c;
  logic signed [17:0] q18_c, qs_c;
  // Hold.
  logic signed [15:0] sc_c;
  logic [20:0]     cten_c;
  logic [3:0]      hstep_c;
  logic [7:0]      hprod_c;
  logic [6:0]      hold_c;
  logic [6:0]      cur_rem_c, new_rem_c, rem_after_c;
  logic signed [15:0] new_held_c;
  logic [15:0]     hm_c;
  // Output.
  logic signed [15:0] o_c;
  // Divider.
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_busy;
  logic [DIV_QW-1:0] div_quo;
  logic [19:0]       gden_c;

  // Input capture: clamp the amount, split sign and magnitude, map the channel.
  always_comb begin
    amt_c = (in_amount > AMOUNT_ONE) ? AMOUNT_ONE : in_amount;
    xm_c  = in_sample[15] ? (17'd0 - 17'(in_sample)) : 17'(in_sample);
    ch_c  = (int'(in_channel) >= CHANNELS) ? CH_W'(CHANNELS - 1) : CH_W'(in_channel);
  end

  // Drive 1 + 13r on the magnitude, and the 1 + 1.2r compensation denominator.
  always_comb begin
    drive_c = 20'(AMOUNT_ONE) + 20'(r_r) * 20'd13;
    dprod_c = 37'(xm_r) * 37'(drive_c);
    dm_c    = 19'((dprod_c + 37'd32768) >> 16);
    rprod_c = 34'(r_r) * 34'd78643;
    den_c   = 18'd65536 + 18'((rprod_c + 34'd32768) >> 16);
  end

  // Shaper argument: plain magnitude for tanh, 1.6x for the negative grit half.
  always_comb begin
    gprod_c = 35'(dm_r) * 35'd52429;
    ga_c    = 20'((gprod_c + 35'd16384) >> 15);
  end

  // tanh by table with linear interpolation; full scale from 6.0 upward.
  always_comb begin
    ti_c    = a_r[19:12];
    t0_c    = tanh_lut(ti_c[5:0]);
    t1_c    = tanh_lut(ti_c[5:0] + 6'd1);
    tdiff_c = 13'(t1_c - t0_c);
    tmul_c  = 25'(tdiff_c) * 25'(a_r[11:0]);
    tint_c  = t0_c + 16'((tmul_c + 25'd2048) >> 12);
    tv_c    = (ti_c >= 8'd48) ? 16'd32768 : tint_c;
  end

  // Signed shaped value from tanh: 0.8 scale for grit, odd symmetry otherwise.
  always_comb begin
    yprod_c = 31'(t_r) * 31'd26214;
    y_c     = 15'((yprod_c + 31'd16384) >> 15);
    tsx_c   = $signed({2'b00, t_r});
    ysx_c   = $signed({3'b000, y_c});
    if (grit_mode_r) begin
      ts_c = -ysx_c;
    end else begin
      ts_c = neg_r ? -tsx_c : tsx_c;
    end
  end

  // Crush level by reciprocal multiply, then step size P = 2^(16 - 11c) in Q8.
  always_comb begin
    cdiff_c = 16'(r_r - CRUSH_KNEE);
    cprod_c = 49'(cdiff_c) * 49'(CRUSH_RECIP);
    c_c     = 17'(cprod_c >> 32);
    e_c     = 21'd1048576 - 21'(c_r) * 21'd11;
    m0_c    = exp2_lut({1'b0, e_c[15:12]});
    m1_c    = exp2_lut({1'b0, e_c[15:12]} + 5'd1);
    mdiff_c = 11'(m1_c - m0_c);
    mmul_c  = 23'(mdiff_c) * 23'(e_c[11:0]);
    m_c     = m0_c + 16'((mmul_c + 23'd2048) >> 12);
    p_c     = 26'((32'(m_r) << ip_r) >> 6);
    smag_c  = s_r[17] ? 17'(-s_r) : 17'(s_r);
    nprod_c = 43'(smag_c) * 43'(p_c);
    n_c     = 18'((nprod_c + 43'h400000) >> 23);
    q18_c   = $signed(18'(div_quo));
    qs_c    = s_r[17] ? -q18_c : q18_c;
  end

  // Hold: saturate, compute the hold length and the channel's next state.
  always_comb begin
    if (s_r > 18'sd32767) begin
      sc_c = 16'sh7FFF;
    end else if (s_r < -18'sd32768) begin
      sc_c = 16'sh8000;
    end else begin
      sc_c = 16'(s_r);
    end
    cten_c      = 21'(c_r) * 21'd10;
    hstep_c     = 4'(cten_c >> 16) + 4'd1;
    hprod_c     = 8'(rate_factor_r) * 8'(hstep_c);
    hold_c      = (hprod_c > 8'd127) ? 7'd127 : 7'(hprod_c);
    cur_rem_c   = rem_r[ch_r];
    new_held_c  = (cur_rem_c == 7'd0) ? sc_c : held_r[ch_r];
    new_rem_c   = (cur_rem_c == 7'd0) ? hold_c : cur_rem_c;
    rem_after_c = (new_rem_c != 7'd0) ? (new_rem_c - 7'd1) : 7'd0;
    hm_c        = new_held_c[15] ? 16'(17'd0 - 17'(new_held_c)) : 16'(new_held_c);
  end

  // Output: restore the sign; a positive result saturates at 32767.
  always_comb begin
    if (hneg_r) begin
      o_c = 16'(17'd0 - 17'(div_quo));
    end else begin
      o_c = (div_quo > 18'd32767) ? 16'sh7FFF : 16'(div_quo);
    end
  end

  // Divider operand selection.
  always_comb begin
    gden_c = 20'd32768 + 20'(dm_r);
    unique case (cmd.div_sel)
      DIV_GRIT: begin
        div_num = DIV_NW'(35'(dm_r) * 35'd39322 + 35'(gden_c >> 1));
        div_den = DIV_DW'(gden_c);
      end
      DIV_QUANT: begin
        div_num = DIV_NW'({n_r, 23'h000000}) + DIV_NW'(p_r >> 1);
        div_den = p_r;
      end
      DIV_OUT: begin
        div_num = DIV_NW'({hm_r, 16'h0000}) + DIV_NW'(den_r >> 1);
        div_den = DIV_DW'(den_r);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  dsbh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // Configuration registers and per-channel hold state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grit_mode_r   <= 1'b0;
      rate_factor_r <= 4'd2;
      for (int i = 0; i < CHANNELS; i++) begin
        held_r[i] <= '0;
        rem_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRIT_MODE:   grit_mode_r   <= cfg_data[0];
          CFG_RATE_FACTOR: rate_factor_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_HOLD) begin
        held_r[ch_r] <= new_held_c;
        rem_r[ch_r]  <= rem_after_c;
      end
    end
  end

  // Working registers, one step per command.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        neg_r      <= in_sample[15];
        xm_r       <= xm_c;
        r_r        <= amt_c;
        ch_r       <= ch_c;
        crush_on_r <= amt_c > CRUSH_KNEE;
        c_r        <= '0;
      end
      OP_DRIVE: begin
        dm_r  <= dm_c;
        den_r <= den_c;
      end
      OP_SHAPE:  a_r <= grit_mode_r ? ga_c : 20'(dm_r);
      OP_TANH:   t_r <= tv_c;
      OP_TSCALE: s_r <= ts_c;
      OP_GRES:   s_r <= (div_quo > 18'd32768) ? 18'sd32768 : $signed(div_quo);
      OP_CRES:   c_r <= (c_c > 17'd65536) ? 17'd65536 : c_c;
      OP_EXPO: begin
        m_r  <= m_c;
        ip_r <= e_c[20:16];
      end
      OP_NMUL: begin
        p_r <= p_c;
        n_r <= n_c;
      end
      OP_QRES: s_r <= qs_c;
      OP_HOLD: begin
        hm_r   <= hm_c;
        hneg_r <= new_held_c[15];
      end
      OP_ORES: out_sample_r <= o_c;
      default: ;
    endcase
  end

  assign stat.grit     = grit_mode_r;
  assign stat.neg      = neg_r;
  assign stat.crush_on = crush_on_r;
  assign stat.div_busy = div_busy;
  assign out_sample    = out_sample_r;
endmodule

// File: src/drive_saturate_bitcrush_hold.sv
// Drive, saturate, bit-crush and sample-hold stage, one word per channel.
// Each word passes drive, tanh or grit shaping, optional crush and the hold;
// the shared divider serves up to three divisions per word. A new word is
// taken only after the previous result is registered, which waits while the
// output slot is full. Synchronous active-low reset clears config and hold state.
// Depends on dsbh_pkg, dsbh_if, dsbh_ctrl and dsbh_dp.
module drive_saturate_bitcrush_hold #(
  parameter int CHANNELS = dsbh_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dsbh_in_if.sink                         in_ch,
  dsbh_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  dsbh_pkg::cfg_idx_t              cfg_index,
  input  logic [dsbh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dsbh_pkg::*;

  dsbh_cmd_t  cmd;
  dsbh_stat_t stat;

  // Sequencer.
  dsbh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  dsbh_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_sample  (in_ch.sample_in),
    .in_amount  (in_ch.amount),
    .in_channel (in_ch.channel),
    .cmd        (cmd),
    .stat       (stat),
    .out_sample (out_ch.sample_out)
  );
endmodule
